>>> src/pfua_pkg.sv
// Shared types, constants and pixel helpers for the pixel format unpack accumulator.
package pfua_pkg;

  localparam int unsigned COLUMNS         = 1024;
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned SUM_WIDTH       = 32;
  localparam int unsigned CNT_WIDTH       = 16;
  localparam int unsigned COL_AW          = $clog2(COLUMNS);
  localparam int unsigned PAL_AW          = $clog2(PALETTE_ENTRIES);

  // Stream payload layout
  localparam int unsigned S_TDATA_W = 112;
  localparam int unsigned M_TDATA_W = 112;
  localparam int unsigned PADDR_W   = 3;

  // Register map (index taken from paddr[2])
  localparam logic REG_PIXEL_FORMAT = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ACC    = 2'd1,
    OP_READ   = 2'd2,
    OP_PAL_WR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PAL_OOR = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CV_ADD  = 2'd0,
    CV_OOR  = 2'd1,
    CV_NONE = 2'd2
  } conv_kind_t;

  // Bit depth codes for packed pixels
  localparam logic [1:0] BPP1 = 2'd0;
  localparam logic [1:0] BPP2 = 2'd1;
  localparam logic [1:0] BPP4 = 2'd2;
  localparam logic [1:0] BPP8 = 2'd3;

  localparam logic [4:0] FMT_PAL1    = 5'd0;
  localparam logic [4:0] FMT_PAL2    = 5'd1;
  localparam logic [4:0] FMT_PAL4    = 5'd2;
  localparam logic [4:0] FMT_PAL8    = 5'd3;
  localparam logic [4:0] FMT_PAL16   = 5'd4;
  localparam logic [4:0] FMT_PAL32   = 5'd5;
  localparam logic [4:0] FMT_PALA8   = 5'd6;
  localparam logic [4:0] FMT_PALA16  = 5'd7;
  localparam logic [4:0] FMT_PALA32  = 5'd8;
  localparam logic [4:0] FMT_IGRAY1  = 5'd9;
  localparam logic [4:0] FMT_IGRAY8  = 5'd12;
  localparam logic [4:0] FMT_GRAY8   = 5'd16;
  localparam logic [4:0] FMT_GRAY16A = 5'd17;
  localparam logic [4:0] FMT_RGB24   = 5'd18;
  localparam logic [4:0] FMT_RGBA32  = 5'd19;
  localparam logic [4:0] FMT_RGB48   = 5'd20;
  localparam logic [4:0] FMT_RGBA64  = 5'd21;
  localparam logic [4:0] FMT_RESET   = FMT_PAL8;

  typedef struct packed {
    conv_kind_t  kind;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } conv_t;

  typedef struct packed {
    logic [SUM_WIDTH-1:0] r;
    logic [SUM_WIDTH-1:0] g;
    logic [SUM_WIDTH-1:0] b;
    logic [CNT_WIDTH-1:0] cnt;
  } acc_t;

  // Pick a packed pixel out of a byte, MSBs first; position wraps per byte.
  function automatic logic [7:0] packed_value(logic [7:0] byte_in, logic [1:0] code,
                                              logic [2:0] pos);
    logic [2:0] sh;
    logic [7:0] mask;
    case (code)
      BPP1: begin
        sh   = ~pos;
        mask = 8'h01;
      end
      BPP2: begin
        sh   = {~pos[1:0], 1'b0};
        mask = 8'h03;
      end
      BPP4: begin
        sh   = {~pos[0], 2'b00};
        mask = 8'h0f;
      end
      default: begin
        sh   = 3'd0;
        mask = 8'hff;
      end
    endcase
    return (byte_in >> sh) & mask;
  endfunction

  // Palette index for the palette formats; zero for the rest.
  function automatic logic [31:0] pal_index(logic [4:0] fmt, logic [63:0] raw,
                                            logic [2:0] pos);
    logic [31:0] idx;
    idx = '0;
    case (fmt)
      FMT_PAL1, FMT_PAL2, FMT_PAL4: idx = 32'(packed_value(raw[7:0], fmt[1:0], pos));
      FMT_PAL8, FMT_PALA16:         idx = 32'(raw[7:0]);
      FMT_PAL16, FMT_PALA32:        idx = 32'(raw[15:0]);
      FMT_PAL32:                    idx = raw[31:0];
      FMT_PALA8:                    idx = 32'(raw[7:4]);
      default:                      idx = '0;
    endcase
    return idx;
  endfunction

  // Saturating add of an 8-bit sample; MSB of the result flags saturation.
  function automatic logic [SUM_WIDTH:0] sat_add(logic [SUM_WIDTH-1:0] s, logic [7:0] v);
    logic [SUM_WIDTH:0] t;
    t = {1'b0, s} + {{(SUM_WIDTH - 7){1'b0}}, v};
    if (t[SUM_WIDTH]) begin
      return {1'b1, {SUM_WIDTH{1'b1}}};
    end
    return {1'b0, t[SUM_WIDTH-1:0]};
  endfunction

  // Read port view of a sum: clamp to 32 bits.
  function automatic logic [31:0] clamp32(logic [SUM_WIDTH-1:0] s);
    logic [SUM_WIDTH+31:0] ext;
    ext = {32'd0, s};
    if ((ext >> 32) != '0) begin
      return 32'hffff_ffff;
    end
    return ext[31:0];
  endfunction

endpackage

>>> src/pfua_convert.sv
// Pixel format decode: one registered source pixel to an 8-bit RGB triple.
module pfua_convert (
  input  logic [4:0]     fmt,
  input  logic [63:0]    raw,
  input  logic [2:0]     pos,
  input  logic [23:0]    pal_entry,
  input  logic           pal_oor,
  output pfua_pkg::conv_t conv
);
  import pfua_pkg::*;

  logic [1:0] code;
  logic [7:0] v;
  logic [7:0] gv;
  logic       alpha_zero;

  always_comb begin
    // gray formats 9..16 share one decoder, bit depth repeats every four
    code = 2'(fmt - FMT_IGRAY1);
    v    = (code == BPP8) ? raw[7:0] : packed_value(raw[7:0], code, pos);
    case (code)
      BPP1:    gv = {8{v[0]}};
      BPP2:    gv = {v[1:0], v[1:0], v[1:0], v[1:0]};
      BPP4:    gv = {v[3:0], v[3:0]};
      default: gv = v;
    endcase

    alpha_zero = ((fmt == FMT_PALA8)  && (raw[3:0] == 4'd0))   ||
                 ((fmt == FMT_PALA16) && (raw[15:8] == 8'd0))  ||
                 ((fmt == FMT_RGBA32) && (raw[31:24] == 8'd0));

    conv.kind = CV_ADD;
    conv.r    = 8'hff;
    conv.g    = 8'hff;
    conv.b    = 8'hff;
    priority if (alpha_zero) begin
      // transparent pixel adds white
      conv.kind = CV_ADD;
    end else if (fmt <= FMT_PALA32) begin
      if (pal_oor) begin
        conv.kind = CV_OOR;
      end else begin
        conv.r = pal_entry[23:16];
        conv.g = pal_entry[15:8];
        conv.b = pal_entry[7:0];
      end
    end else if (fmt <= FMT_IGRAY8) begin
      conv.r = ~gv;
      conv.g = ~gv;
      conv.b = ~gv;
    end else if (fmt <= FMT_GRAY8) begin
      conv.r = gv;
      conv.g = gv;
      conv.b = gv;
    end else if (fmt == FMT_GRAY16A) begin
      conv.r = raw[7:0];
      conv.g = raw[7:0];
      conv.b = raw[7:0];
    end else if ((fmt == FMT_RGB24) || (fmt == FMT_RGBA32)) begin
      conv.r = raw[7:0];
      conv.g = raw[15:8];
      conv.b = raw[23:16];
    end else if ((fmt == FMT_RGB48) || (fmt == FMT_RGBA64)) begin
      // 16-bit samples, keep the high byte
      conv.r = raw[15:8];
      conv.g = raw[31:24];
      conv.b = raw[47:40];
    end else begin
      conv.kind = CV_NONE;
    end
  end

endmodule

>>> src/pixel_format_unpack_accumulate_top.sv
// Top level of the pixel format unpack accumulator.
//
// Box-filter accumulator for image down-scaling. Each input transaction carries an op in
// s_tuser: clear a column, accumulate one source pixel into a column, read a column, or
// write a palette entry. Accumulate decodes the pixel in the format held in the
// pixel_format register (APB, byte address 0) into 8-bit RGB and adds it into the
// column's red, green and blue sums and pixel count; sums and count saturate, and a
// palette index at or beyond the palette size is skipped with status 1. Every input
// transaction gives exactly one output transaction, in order.
// Rate: one transaction per cycle sustained while the output is not stalled. The column
// sums live in a 1024 x 112-bit memory read at accept and written back as the item leaves
// stage 1; a write-to-read bypass on that memory lets the same column be hit in back to
// back cycles. The palette is a 256 x 24-bit memory read at accept and written directly
// at the accept of a palette write. Neither memory is cleared after reset: a column must
// be cleared and a palette entry written before use. Change pixel_format only while idle.
module pixel_format_unpack_accumulate_top (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [9:0] column, [73:10] raw_pixel, [76:74] sub_position, [84:77] entry_index,
  // [92:85] entry_red, [100:93] entry_green, [108:101] entry_blue, rest zero
  input  logic [pfua_pkg::S_TDATA_W-1:0]     s_tdata,
  // [1:0] op
  input  logic [1:0]                         s_tuser,
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] red_total, [63:32] green_total, [95:64] blue_total, [111:96] pixel_count
  output logic [pfua_pkg::M_TDATA_W-1:0]     m_tdata,
  // [1:0] status
  output logic [1:0]                         m_tuser,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfua_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import pfua_pkg::*;

  // ---------------- configuration ----------------
  logic [4:0] fmt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PIXEL_FORMAT) ? {27'd0, fmt} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= FMT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PIXEL_FORMAT)) begin
      fmt <= pwdata[4:0];
    end
  end

  // ---------------- input unpack ----------------
  op_t         in_op;
  logic [9:0]  in_col;
  logic [63:0] in_raw;
  logic [2:0]  in_pos;
  logic [7:0]  in_eidx;
  logic [23:0] in_entry;
  logic [31:0] in_pidx;

  assign in_op    = op_t'(s_tuser);
  assign in_col   = s_tdata[9:0];
  assign in_raw   = s_tdata[73:10];
  assign in_pos   = s_tdata[76:74];
  assign in_eidx  = s_tdata[84:77];
  // entry_red in the top byte of a palette word
  assign in_entry = {s_tdata[92:85], s_tdata[100:93], s_tdata[108:101]};
  assign in_pidx  = pal_index(fmt, in_raw, in_pos);

  // ---------------- handshake ----------------
  logic s1_valid;
  logic out_free;
  logic s1_adv;
  logic accept;

  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && out_free;
  assign s_tready = !rst && (!s1_valid || out_free);
  assign accept   = s_tvalid && s_tready;

  // ---------------- stage 1 registers ----------------
  op_t         s1_op;
  logic [9:0]  s1_col;
  logic [63:0] s1_raw;
  logic [2:0]  s1_pos;
  logic        s1_oor;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= in_op;
      s1_col <= in_col;
      s1_raw <= in_raw;
      s1_pos <= in_pos;
      s1_oor <= !(in_pidx < PALETTE_ENTRIES);
    end
  end

  // ---------------- palette memory ----------------
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] pal_rd;

  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_PAL_WR) && (32'(in_eidx) < PALETTE_ENTRIES)) begin
      pal_mem[in_eidx[PAL_AW-1:0]] <= in_entry;
    end
    if (accept) begin
      pal_rd <= pal_mem[in_pidx[PAL_AW-1:0]];
    end
  end

  // ---------------- column accumulator memory ----------------
  acc_t             acc_mem [COLUMNS];
  acc_t             acc_rd;
  acc_t             wr_data;
  logic             wr_en;
  logic [COL_AW-1:0] wr_addr;

  assign wr_addr = s1_col[COL_AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      // bypass the write-back of the item ahead when it hits the same column
      if (wr_en && (wr_addr == in_col[COL_AW-1:0])) begin
        acc_rd <= wr_data;
      end else begin
        acc_rd <= acc_mem[in_col[COL_AW-1:0]];
      end
    end
  end

  // ---------------- pixel decode ----------------
  conv_t conv;

  pfua_convert u_convert (
    .fmt       (fmt),
    .raw       (s1_raw),
    .pos       (s1_pos),
    .pal_entry (pal_rd),
    .pal_oor   (s1_oor),
    .conv      (conv)
  );

  // ---------------- read-modify-write ----------------
  logic               col_ok;
  logic               do_add;
  logic [SUM_WIDTH:0] sum_r;
  logic [SUM_WIDTH:0] sum_g;
  logic [SUM_WIDTH:0] sum_b;
  logic               cnt_sat;
  logic               any_sat;
  status_t            status_next;
  logic [M_TDATA_W-1:0] tdata_next;

  always_comb begin
    col_ok  = 32'(s1_col) < COLUMNS;
    do_add  = (s1_op == OP_ACC) && (conv.kind == CV_ADD) && col_ok;
    sum_r   = sat_add(acc_rd.r, conv.r);
    sum_g   = sat_add(acc_rd.g, conv.g);
    sum_b   = sat_add(acc_rd.b, conv.b);
    cnt_sat = &acc_rd.cnt;
    any_sat = sum_r[SUM_WIDTH] || sum_g[SUM_WIDTH] || sum_b[SUM_WIDTH] || cnt_sat;

    wr_en   = s1_adv && col_ok && ((s1_op == OP_CLEAR) || do_add);
    if (s1_op == OP_CLEAR) begin
      wr_data = '0;
    end else begin
      wr_data.r   = sum_r[SUM_WIDTH-1:0];
      wr_data.g   = sum_g[SUM_WIDTH-1:0];
      wr_data.b   = sum_b[SUM_WIDTH-1:0];
      wr_data.cnt = cnt_sat ? acc_rd.cnt : acc_rd.cnt + CNT_WIDTH'(1);
    end

    status_next = ST_OK;
    if ((s1_op == OP_ACC) && (conv.kind == CV_OOR)) begin
      status_next = ST_PAL_OOR;
    end else if (do_add && any_sat) begin
      status_next = ST_SAT;
    end

    tdata_next = '0;
    if ((s1_op == OP_READ) && col_ok) begin
      tdata_next = {acc_rd.cnt, clamp32(acc_rd.b), clamp32(acc_rd.g), clamp32(acc_rd.r)};
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= tdata_next;
      m_tuser <= status_next;
    end
  end

endmodule

>>> src/pfua_checker.sv
// Port-level checks for the pixel format unpack accumulator, bound to the top level.
module pfua_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pfua_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [1:0]                     m_tuser
);
  import pfua_pkg::*;

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // a flagged result is never a read, so it carries no totals
  a_flag_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == ST_PAL_OOR) || (m_tuser == ST_SAT)) |-> m_tdata == '0)
    else $error("flagged result carries data");

  // pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a fresh result follows an earlier accepted transaction
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching transaction");

endmodule

bind pixel_format_unpack_accumulate_top pfua_checker u_pfua_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
